[src/cbr_pkg.sv]
// shared codes for the cylinder/box relation block
// register indexes, command codes and relation codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbr_pkg;

    // configuration port
    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS  = 32;
    localparam int unsigned TIME_BITS      = 32;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_CENTER_X   = 3'd0;
    localparam cfg_index_t REG_CENTER_Y   = 3'd1;
    localparam cfg_index_t REG_RADIUS     = 3'd2;
    localparam cfg_index_t REG_START_TIME = 3'd3;
    localparam cfg_index_t REG_END_TIME   = 3'd4;

    // item commands
    localparam logic CMD_BOX   = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    // result codes
    typedef logic [1:0] relation_t;

    localparam relation_t REL_DISJOINT  = 2'd0;
    localparam relation_t REL_INTERSECT = 2'd1;
    localparam relation_t REL_INSIDE    = 2'd2;

endpackage

`default_nettype wire

[src/cylinder_box_relation.sv]
// cylinder_box_relation: tests space-time boxes and timed points against a
// query cylinder (circle centre, radius, closed time interval) held in registers.
// Each item enters on the in channel with valid and stall. Its result leaves on
// the out channel with valid and stall.
// Configuration is a write port (cfg_we, cfg_index, cfg_data) with no wait state.
// Only write it while no item is in flight.
// An accepted item passes through four register stages: axis differences,
// squares, sums of squares, and the compare into the output register.
// Throughput: one item per cycle. An item can enter in every cycle while the
// receiver takes results.
// A stall on the output holds the output register. Each stage then fills its
// empty slot, and once every stage is full in_stall rises. Nothing is dropped
// or repeated.
// Reset: rst_n clears all stage valid bits and the registers (centre 0,
// radius 0, interval [0, 0]).
// depends on cbr_pkg
`timescale 1ns / 1ps
`default_nettype none

module cylinder_box_relation
    import cbr_pkg::*;
#(
    parameter int unsigned COORD_BITS = 24
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    // configuration port
    input  wire logic                         cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]     cfg_data,

    // item input
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         command,
    input  wire logic signed [COORD_BITS-1:0] x_min,
    input  wire logic signed [COORD_BITS-1:0] x_max,
    input  wire logic signed [COORD_BITS-1:0] y_min,
    input  wire logic signed [COORD_BITS-1:0] y_max,
    input  wire logic [TIME_BITS-1:0]         t_min,
    input  wire logic [TIME_BITS-1:0]         t_max,

    // result output
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [1:0]                        relation
);

    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned SQ = 2 * COORD_BITS;
    localparam int unsigned SM = 2 * COORD_BITS + 1;
    localparam int unsigned R2 = 2 * COORD_BITS - 2;

    // magnitude of an extended difference
    function automatic logic [CB-1:0] mag(input logic signed [CB:0] d);
        logic signed [CB:0] n;
        n = -d;
        mag = d[CB] ? n[CB-1:0] : d[CB-1:0];
    endfunction

    // distance from the centre to a [lo, hi] interval on one axis
    function automatic logic [CB-1:0] gap(input logic signed [CB:0] d_lo,
                                          input logic signed [CB:0] d_hi);
        gap = (d_lo > 0) ? d_lo[CB-1:0] : ((d_hi > 0) ? d_hi[CB-1:0] : '0);
    endfunction

    // configuration registers
    logic signed [CB-1:0]   center_x_reg;
    logic signed [CB-1:0]   center_y_reg;
    logic [CB-2:0]          radius_reg;
    logic [TIME_BITS-1:0]   start_time_reg;
    logic [TIME_BITS-1:0]   end_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            radius_reg     <= '0;
            start_time_reg <= '0;
            end_time_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X:   center_x_reg   <= cfg_data[CB-1:0];
                REG_CENTER_Y:   center_y_reg   <= cfg_data[CB-1:0];
                REG_RADIUS:     radius_reg     <= cfg_data[CB-2:0];
                REG_START_TIME: start_time_reg <= cfg_data[TIME_BITS-1:0];
                REG_END_TIME:   end_time_reg   <= cfg_data[TIME_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // stage enables, back to front
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic en1, en2, en3, en4;

    assign en4      = !out_valid_reg || !out_stall;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg  <= in_valid;
            if (en2) s2_valid_reg  <= s1_valid_reg;
            if (en3) s3_valid_reg  <= s2_valid_reg;
            if (en4) out_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: axis differences, gaps and time tests
    logic signed [CB:0] cx_e, cy_e;
    logic [CB-1:0]      ax_next, bx_next, ay_next, by_next, gx_next, gy_next;
    logic               btime_next, ptime_next;

    always_comb
    begin
        cx_e       = {center_x_reg[CB-1], center_x_reg};
        cy_e       = {center_y_reg[CB-1], center_y_reg};
        ax_next    = mag({x_min[CB-1], x_min} - cx_e);
        bx_next    = mag({x_max[CB-1], x_max} - cx_e);
        ay_next    = mag({y_min[CB-1], y_min} - cy_e);
        by_next    = mag({y_max[CB-1], y_max} - cy_e);
        gx_next    = gap({x_min[CB-1], x_min} - cx_e, cx_e - {x_max[CB-1], x_max});
        gy_next    = gap({y_min[CB-1], y_min} - cy_e, cy_e - {y_max[CB-1], y_max});
        btime_next = !(t_min > end_time_reg || t_max < start_time_reg);
        ptime_next = (t_min >= start_time_reg) && (t_min <= end_time_reg);
    end

    logic [CB-1:0] ax_reg, bx_reg, ay_reg, by_reg, gx_reg, gy_reg;
    logic          s1_cmd_reg, s1_btime_reg, s1_ptime_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ax_reg       <= ax_next;
            bx_reg       <= bx_next;
            ay_reg       <= ay_next;
            by_reg       <= by_next;
            gx_reg       <= gx_next;
            gy_reg       <= gy_next;
            s1_cmd_reg   <= command;
            s1_btime_reg <= btime_next;
            s1_ptime_reg <= ptime_next;
        end
    end

    // stage 2: squares
    logic [SQ-1:0] ax2_reg, bx2_reg, ay2_reg, by2_reg, gx2_reg, gy2_reg;
    logic [R2-1:0] r2_reg;
    logic          s2_cmd_reg, s2_btime_reg, s2_ptime_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            ax2_reg      <= SQ'(ax_reg) * SQ'(ax_reg);
            bx2_reg      <= SQ'(bx_reg) * SQ'(bx_reg);
            ay2_reg      <= SQ'(ay_reg) * SQ'(ay_reg);
            by2_reg      <= SQ'(by_reg) * SQ'(by_reg);
            gx2_reg      <= SQ'(gx_reg) * SQ'(gx_reg);
            gy2_reg      <= SQ'(gy_reg) * SQ'(gy_reg);
            r2_reg       <= R2'(radius_reg) * R2'(radius_reg);
            s2_cmd_reg   <= s1_cmd_reg;
            s2_btime_reg <= s1_btime_reg;
            s2_ptime_reg <= s1_ptime_reg;
        end
    end

    // stage 3: sums of squares for the gap and the four corners
    logic [SM-1:0] sg_reg, saa_reg, sab_reg, sba_reg, sbb_reg;
    logic [R2-1:0] s3_r2_reg;
    logic          s3_cmd_reg, s3_btime_reg, s3_ptime_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            sg_reg       <= {1'b0, gx2_reg} + {1'b0, gy2_reg};
            saa_reg      <= {1'b0, ax2_reg} + {1'b0, ay2_reg};
            sab_reg      <= {1'b0, ax2_reg} + {1'b0, by2_reg};
            sba_reg      <= {1'b0, bx2_reg} + {1'b0, ay2_reg};
            sbb_reg      <= {1'b0, bx2_reg} + {1'b0, by2_reg};
            s3_r2_reg    <= r2_reg;
            s3_cmd_reg   <= s2_cmd_reg;
            s3_btime_reg <= s2_btime_reg;
            s3_ptime_reg <= s2_ptime_reg;
        end
    end

    // stage 4: compares against the squared radius
    logic [SM-1:0] r2_e;
    logic          gap_ok, corners_in, point_in;
    relation_t     relation_next;
    relation_t     relation_reg;
    logic          out_cmd_reg;

    always_comb
    begin
        r2_e       = {3'b000, s3_r2_reg};
        gap_ok     = sg_reg <= r2_e;
        point_in   = saa_reg < r2_e;
        corners_in = point_in && (sab_reg < r2_e) && (sba_reg < r2_e) && (sbb_reg < r2_e);
        if (s3_cmd_reg == CMD_POINT)
            relation_next = (s3_ptime_reg && point_in) ? REL_INTERSECT : REL_DISJOINT;
        else if (!s3_btime_reg || !gap_ok)
            relation_next = REL_DISJOINT;
        else if (corners_in)
            relation_next = REL_INSIDE;
        else
            relation_next = REL_INTERSECT;
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            relation_reg <= relation_next;
            out_cmd_reg  <= s3_cmd_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign relation  = relation_reg;

    // a point test never reports a box fully inside
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_cmd_reg == CMD_POINT) |-> relation != REL_INSIDE)
        else $error("point item gave inside result");

    // input stalls only when every stage holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

    // a taken result with nothing behind it empties the output
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !s3_valid_reg |=> !out_valid)
        else $error("result repeated");

endmodule

`default_nettype wire

[tb/sv/cylinder_box_relation_test.sv]
// self-checking testbench for cylinder_box_relation: directed and random boxes and
// timed points, checked against an in-bench classifier over several cylinders
// depends on cbr_pkg and cylinder_box_relation
`timescale 1ns / 1ps

module cylinder_box_relation_test;
    import cbr_pkg::*;

    localparam int unsigned COORD_BITS      = 24;
    localparam int unsigned CLK_PERIOD      = 4;
    localparam int unsigned PIPE_LATENCY    = 4;
    localparam int unsigned WATCHDOG_LIMIT  = 200;
    localparam int unsigned RANDOM_PHASES   = 8;
    localparam int unsigned ITEMS_PER_PHASE = 125;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-2:0]        radius_t;
    typedef logic [TIME_BITS-1:0]         stamp_t;
    typedef logic [CFG_DATA_BITS-1:0]     cfg_word_t;

    typedef struct packed {
        logic   command;
        coord_t x_min;
        coord_t x_max;
        coord_t y_min;
        coord_t y_max;
        stamp_t t_min;
        stamp_t t_max;
    } probe_t;

    localparam coord_t  COORD_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t  COORD_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam radius_t RADIUS_MAX = '1;
    localparam stamp_t  TIME_MAX   = '1;

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      cfg_we      = 1'b0;
    cfg_index_t cfg_index  = '0;
    cfg_word_t cfg_data    = '0;
    logic      in_valid    = 1'b0;
    logic      in_stall;
    probe_t    on_wire     = '0;
    logic      command;
    coord_t    x_min;
    coord_t    x_max;
    coord_t    y_min;
    coord_t    y_max;
    stamp_t    t_min;
    stamp_t    t_max;
    logic      out_valid;
    logic      out_stall   = 1'b0;
    relation_t relation;

    // bench copy of the cylinder registers, at their reset values
    coord_t  circle_x  = '0;
    coord_t  circle_y  = '0;
    radius_t circle_r  = '0;
    stamp_t  window_lo = '0;
    stamp_t  window_hi = '0;

    probe_t      pending_probes[$];
    relation_t   expected_relations[$];
    bit          send_bubbles = 1'b1;
    bit          recv_bubbles = 1'b1;
    int unsigned send_hold    = 0;
    int unsigned recv_hold    = 0;
    int unsigned quiet_cycles = 0;
    int          failures     = 0;

    assign command = on_wire.command;
    assign x_min   = on_wire.x_min;
    assign x_max   = on_wire.x_max;
    assign y_min   = on_wire.y_min;
    assign y_max   = on_wire.y_max;
    assign t_min   = on_wire.t_min;
    assign t_max   = on_wire.t_max;

    cylinder_box_relation #(
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .x_min     (x_min),
        .x_max     (x_max),
        .y_min     (y_min),
        .y_max     (y_max),
        .t_min     (t_min),
        .t_max     (t_max),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .relation  (relation)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // exact distance helpers, all in 64-bit integers
    function automatic longint unsigned span(input longint a, input longint b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic longint unsigned dist2(input longint unsigned dx,
                                              input longint unsigned dy);
        return dx * dx + dy * dy;
    endfunction

    function automatic longint unsigned gap_to(input longint c, input longint lo,
                                               input longint hi);
        if (c < lo)
            return lo - c;
        if (c > hi)
            return c - hi;
        return 0;
    endfunction

    // relation of one item to the current cylinder
    function automatic relation_t classify_probe(input probe_t p);
        longint          cx;
        longint          cy;
        longint          x1;
        longint          x2;
        longint          y1;
        longint          y2;
        longint unsigned r;
        longint unsigned r2;
        relation_t       rel;
        cx  = longint'(circle_x);
        cy  = longint'(circle_y);
        x1  = longint'(p.x_min);
        x2  = longint'(p.x_max);
        y1  = longint'(p.y_min);
        y2  = longint'(p.y_max);
        r   = circle_r;
        r2  = r * r;
        rel = REL_DISJOINT;
        if (p.command == CMD_POINT)
        begin
            // closed time window, strictly inside the circle
            if (p.t_min >= window_lo && p.t_min <= window_hi &&
                dist2(span(cx, x1), span(cy, y1)) < r2)
                rel = REL_INTERSECT;
        end
        else if (!(p.t_min > window_hi || p.t_max < window_lo))
        begin
            // nearest point on or within r, then every corner strictly inside
            if (dist2(gap_to(cx, x1, x2), gap_to(cy, y1, y2)) <= r2)
            begin
                if (dist2(span(cx, x1), span(cy, y1)) < r2 &&
                    dist2(span(cx, x1), span(cy, y2)) < r2 &&
                    dist2(span(cx, x2), span(cy, y1)) < r2 &&
                    dist2(span(cx, x2), span(cy, y2)) < r2)
                    rel = REL_INSIDE;
                else
                    rel = REL_INTERSECT;
            end
        end
        return rel;
    endfunction

    // stimulus helpers
    function automatic coord_t jitter(input coord_t base, input longint reach);
        return coord_t'(longint'(base) + longint'($urandom_range(0, 2 * reach)) - reach);
    endfunction

    function automatic stamp_t time_near();
        case ($urandom_range(0, 2))
            0: return window_lo + stamp_t'($urandom_range(0, 6)) - stamp_t'(3);
            1: return window_hi + stamp_t'($urandom_range(0, 6)) - stamp_t'(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic coord_t pick_centre();
        if ($urandom_range(0, 1) == 0)
            return coord_t'($urandom);
        return coord_t'($urandom_range(0, 2000)) - coord_t'(1000);
    endfunction

    function automatic probe_t random_probe();
        probe_t p;
        longint reach;
        p.command = ($urandom_range(0, 1) == 0) ? CMD_BOX : CMD_POINT;
        p.x_min   = coord_t'($urandom);
        p.x_max   = coord_t'($urandom);
        p.y_min   = coord_t'($urandom);
        p.y_max   = coord_t'($urandom);
        p.t_min   = $urandom;
        p.t_max   = $urandom;
        // a fifth of the items are pure noise
        if ($urandom_range(0, 9) < 2)
            return p;
        reach   = (longint'(circle_r) * 2 + 8) >>> $urandom_range(0, 3);
        p.x_min = jitter(circle_x, reach);
        p.y_min = jitter(circle_y, reach);
        if (p.command == CMD_BOX)
        begin
            p.x_max = coord_t'(longint'(p.x_min) + $urandom_range(0, reach));
            p.y_max = coord_t'(longint'(p.y_min) + $urandom_range(0, reach));
            if ($urandom_range(0, 7) == 0)
                {p.x_min, p.x_max} = {p.x_max, p.x_min};
            if ($urandom_range(0, 7) == 0)
                {p.y_min, p.y_max} = {p.y_max, p.y_min};
        end
        p.t_min = time_near();
        if ($urandom_range(0, 1) == 0)
            p.t_max = time_near();
        else
            p.t_max = p.t_min + stamp_t'($urandom_range(0, 1 << 20));
        return p;
    endfunction

    function automatic void add_box(input coord_t xa, input coord_t xb, input coord_t ya,
                                    input coord_t yb, input stamp_t ta, input stamp_t tb);
        pending_probes.push_back({CMD_BOX, xa, xb, ya, yb, ta, tb});
    endfunction

    // a point carries junk in the fields it does not use
    function automatic void add_point(input coord_t xa, input coord_t ya, input stamp_t ta);
        pending_probes.push_back({CMD_POINT, xa, coord_t'($urandom), ya,
                                  coord_t'($urandom), ta, stamp_t'($urandom)});
    endfunction

    // register write, mirrored into the bench copy
    task automatic write_reg(input cfg_index_t idx, input cfg_word_t data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_CENTER_X:   circle_x  = data[COORD_BITS-1:0];
            REG_CENTER_Y:   circle_y  = data[COORD_BITS-1:0];
            REG_RADIUS:     circle_r  = data[COORD_BITS-2:0];
            REG_START_TIME: window_lo = data[TIME_BITS-1:0];
            REG_END_TIME:   window_hi = data[TIME_BITS-1:0];
            default:        ;
        endcase
    endtask

    // all five registers, with junk above the width of centre and radius, then a write to a spare index
    task automatic set_cylinder(input coord_t cx, input coord_t cy, input radius_t r,
                                input stamp_t lo, input stamp_t hi);
        cfg_word_t word;
        word = $urandom;
        word[COORD_BITS-1:0] = cx;
        write_reg(REG_CENTER_X, word);
        word = $urandom;
        word[COORD_BITS-1:0] = cy;
        write_reg(REG_CENTER_Y, word);
        word = $urandom;
        word[COORD_BITS-2:0] = r;
        write_reg(REG_RADIUS, word);
        write_reg(REG_START_TIME, lo);
        write_reg(REG_END_TIME, hi);
        write_reg(cfg_index_t'($urandom_range(int'(REG_END_TIME) + 1,
                                              (1 << CFG_INDEX_BITS) - 1)), $urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every item is sent and every result is back
    task automatic drain();
        while (pending_probes.size() != 0 || in_valid || expected_relations.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY) @(negedge clk);
    endtask

    // item sender
    always @(posedge clk or negedge rst_n)
    begin : feed
        probe_t staged;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            send_hold <= 0;
        end
        else
        begin
            // item taken: record the relation it should produce
            if (in_valid && !in_stall)
                expected_relations.push_back(classify_probe(on_wire));
            // line free: sit out the gap, then present the next item
            if (!in_valid || !in_stall)
            begin
                if (send_hold != 0)
                begin
                    in_valid  <= 1'b0;
                    send_hold <= send_hold - 1;
                end
                else if (pending_probes.size() != 0)
                begin
                    staged    = pending_probes.pop_front();
                    on_wire   <= staged;
                    in_valid  <= 1'b1;
                    send_hold <= send_bubbles ? $urandom_range(0, 4) : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : collect
        relation_t   want;
        int unsigned draw;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_hold <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (expected_relations.size() == 0)
            begin
                $error("relation: expected none, got %0d", relation);
                failures++;
            end
            else
            begin
                want = expected_relations.pop_front();
                if (relation !== want)
                begin
                    $error("relation: expected %0d, got %0d", want, relation);
                    failures++;
                end
            end
            // after each item, draw a random hold and stall while it runs, if recv_bubbles is set
            draw = recv_bubbles ? $urandom_range(0, 4) : 0;
            recv_hold <= draw;
            out_stall <= (draw != 0);
        end
        else if (recv_hold != 0)
        begin
            recv_hold <= recv_hold - 1;
            out_stall <= (recv_hold > 1);
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // sequence of phases
    initial
    begin
        radius_t r_pick;
        stamp_t  lo_pick;
        stamp_t  hi_pick;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // registers at reset: zero radius, interval [0, 0]
        @(negedge clk);
        add_box(-1, 1, -1, 1, 0, 0);
        add_point(0, 0, 0);
        add_box(1, 5, 1, 5, 0, 0);
        drain();

        // edges of a small cylinder
        set_cylinder(100, -200, 1000, 1000, 2000);
        @(negedge clk);
        add_point(100, -200, 1000);
        add_point(100, -200, 2000);
        add_point(100, -200, 999);
        add_point(100, -200, 2001);
        add_point(1100, -200, 1500);
        add_point(1099, -200, 1500);
        add_box(90, 110, -210, -190, 1500, 1500);
        add_box(100, 700, -200, 600, 1000, 1000);
        add_box(1100, 1200, -200, -200, 1500, 1600);
        add_box(1101, 1200, -200, -200, 1500, 1600);
        add_box(90, 110, -210, -190, 2001, 3000);
        add_box(90, 110, -210, -190, 0, 999);
        add_box(90, 110, -210, -190, 2000, 5000);
        add_box(90, 110, -210, -190, 1800, 1200);
        add_box(110, 90, -190, -210, 1500, 1500);
        add_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 0, TIME_MAX);
        drain();

        // centre in a corner of the plane, largest radius, whole time range
        set_cylinder(COORD_MIN, COORD_MAX, RADIUS_MAX, 0, TIME_MAX);
        @(negedge clk);
        add_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 0, TIME_MAX);
        add_point(COORD_MAX, COORD_MIN, TIME_MAX);
        add_point(COORD_MIN, COORD_MAX, 0);
        add_box(COORD_MIN, COORD_MIN + 10, COORD_MAX - 10, COORD_MAX, TIME_MAX, TIME_MAX);

        // random items over a range of cylinders
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0: set_cylinder(COORD_MAX, COORD_MIN, '0, TIME_MAX, '0);
                1: set_cylinder(COORD_MIN, COORD_MIN, RADIUS_MAX, '0, TIME_MAX);
                default:
                begin
                    case ($urandom_range(0, 2))
                        0: r_pick = radius_t'($urandom_range(0, 16));
                        1: r_pick = radius_t'($urandom_range(0, 1 << 12));
                        default: r_pick = radius_t'($urandom);
                    endcase
                    lo_pick = $urandom;
                    if ($urandom_range(0, 4) == 0)
                        hi_pick = $urandom;
                    else
                        hi_pick = lo_pick + stamp_t'($urandom_range(0, 1 << 20));
                    set_cylinder(pick_centre(), pick_centre(), r_pick, lo_pick, hi_pick);
                end
            endcase
            @(negedge clk);
            // some phases run without gaps on one side
            send_bubbles = (phase % 3 != 1);
            recv_bubbles = (phase % 3 != 2);
            repeat (ITEMS_PER_PHASE) pending_probes.push_back(random_probe());
        end
        drain();

        if (failures == 0 && expected_relations.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
src/cbr_pkg.sv
src/cylinder_box_relation.sv
tb/sv/cylinder_box_relation_test.sv
